// ----- design/frc_pkg.sv -----
// Shared types and constants for the fraction reduce and compare block.
package frc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] ORDER_A_GT = 2'd0;
  localparam logic [1:0] ORDER_B_GT = 2'd1;
  localparam logic [1:0] ORDER_EQ   = 2'd2;

  typedef struct packed {
    logic signed [31:0] num_a;
    logic signed [31:0] den_a;
    logic signed [31:0] num_b;
    logic signed [31:0] den_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] red_num_a;
    logic        [30:0] red_den_a;
    logic signed [31:0] red_num_b;
    logic        [30:0] red_den_b;
    logic        [1:0]  order;
    logic               zero_den_error;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EUC,
    S_DIV_REM,
    S_DIV_NUM,
    S_DIV_DEN,
    S_MUL_A,
    S_MUL_B,
    S_EMIT
  } state_t;

endpackage

// ----- design/fraction_reduce_and_compare_top.sv -----
// Top level of the fraction reduce and compare block with its sequencer and shared divider.
//
//   Channel  Direction  Payload          Handshake
//   in_      input      frc_pkg::in_t    in_valid / in_stall
//   out_     output     frc_pkg::out_t   out_valid / out_stall
//
// Every remainder and quotient, including the Euclid remainder steps of the two fractions, goes
// through one restoring divider that retires one quotient bit per cycle.
// The input is stalled until the result is written, so a new transaction is taken only then.
// A zero denominator skips the arithmetic and goes straight to the emit state.
// Reset clears the sequencer and the output valid; no memory needs clearing.
// A finished result waits in the output register while the next input transaction is taken.
module fraction_reduce_and_compare_top #(
  parameter int VALUE_WIDTH = frc_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  frc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output frc_pkg::out_t out_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] sat_of(input logic [W-1:0] m);
    sat_of = (m > LIM) ? LIM : m;
  endfunction

  function automatic logic [31:0] enc_num(input logic [W-1:0] m, input logic neg);
    logic [31:0] v;
    v = 32'(sat_of(m));
    enc_num = neg ? (~v + 32'd1) : v;
  endfunction

  frc_pkg::state_t state_r, state_nxt;
  logic            sel_r, sel_nxt;
  frc_pkg::in_t    hold_r, hold_nxt;
  logic [W-1:0]    nm_r, nm_nxt, dm_r, dm_nxt, p_r, p_nxt, q_r, q_nxt;
  logic            nneg_r, nneg_nxt, dneg_r, dneg_nxt;
  logic [W-1:0]    div_rem_r, div_rem_nxt, div_quo_r, div_quo_nxt;
  logic [CW-1:0]   div_cnt_r, div_cnt_nxt;
  logic [W-1:0]    num_a_r, num_a_nxt, den_a_r, den_a_nxt;
  logic [W-1:0]    num_b_r, num_b_nxt, den_b_r, den_b_nxt;
  logic            neg_a_r, neg_a_nxt, neg_b_r, neg_b_nxt;
  logic            err_r, err_nxt;
  logic [2*W-1:0]  prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;
  logic            out_valid_r, out_valid_nxt;
  frc_pkg::out_t   out_data_r, out_data_nxt;

  logic            in_fire, emit_fire, div_last, div_ge;
  logic [W-1:0]    div_dsr, div_rem_step, div_quo_step;
  logic [W:0]      div_trial, div_sub;
  logic [W-1:0]    mul_x, mul_y;
  logic [2*W-1:0]  mul_p;
  logic [W-1:0]    an_raw, ad_raw, bn_raw, bd_raw;
  logic            frac_neg;
  logic [1:0]      order_val;

  assign in_stall  = (state_r != frc_pkg::S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (state_r == frc_pkg::S_EMIT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign an_raw = in_data.num_a[W-1:0];
  assign ad_raw = in_data.den_a[W-1:0];
  assign bn_raw = hold_r.num_b[W-1:0];
  assign bd_raw = hold_r.den_b[W-1:0];

  assign div_dsr      = (state_r == frc_pkg::S_DIV_REM) ? q_r : p_r;
  assign div_trial    = {div_rem_r, div_quo_r[W-1]};
  assign div_sub      = div_trial - {1'b0, div_dsr};
  assign div_ge       = (div_trial >= {1'b0, div_dsr});
  assign div_rem_step = div_ge ? div_sub[W-1:0] : div_trial[W-1:0];
  assign div_quo_step = {div_quo_r[W-2:0], div_ge};
  assign div_last     = (div_cnt_r == CW'(W - 1));

  assign mul_x = (state_r == frc_pkg::S_MUL_A) ? num_a_r : num_b_r;
  assign mul_y = (state_r == frc_pkg::S_MUL_A) ? den_b_r : den_a_r;
  assign mul_p = mul_x * mul_y;

  assign frac_neg = (div_quo_step != '0) && (nneg_r != dneg_r);

  always_comb begin
    if (neg_a_r != neg_b_r) begin
      order_val = neg_a_r ? frc_pkg::ORDER_B_GT : frc_pkg::ORDER_A_GT;
    end else if (prod_a_r == prod_b_r) begin
      order_val = frc_pkg::ORDER_EQ;
    end else if ((prod_a_r > prod_b_r) ^ neg_a_r) begin
      order_val = frc_pkg::ORDER_A_GT;
    end else begin
      order_val = frc_pkg::ORDER_B_GT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frc_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (ad_raw == '0 || in_data.den_b[W-1:0] == '0) ?
                      frc_pkg::S_EMIT : frc_pkg::S_EUC;
        end
      end
      frc_pkg::S_EUC: begin
        state_nxt = (q_r == '0) ? frc_pkg::S_DIV_NUM : frc_pkg::S_DIV_REM;
      end
      frc_pkg::S_DIV_REM: begin
        if (div_last) begin
          state_nxt = frc_pkg::S_EUC;
        end
      end
      frc_pkg::S_DIV_NUM: begin
        if (div_last) begin
          state_nxt = frc_pkg::S_DIV_DEN;
        end
      end
      frc_pkg::S_DIV_DEN: begin
        if (div_last) begin
          state_nxt = sel_r ? frc_pkg::S_MUL_A : frc_pkg::S_EUC;
        end
      end
      frc_pkg::S_MUL_A: state_nxt = frc_pkg::S_MUL_B;
      frc_pkg::S_MUL_B: state_nxt = frc_pkg::S_EMIT;
      frc_pkg::S_EMIT: begin
        if (emit_fire) begin
          state_nxt = frc_pkg::S_IDLE;
        end
      end
      default: state_nxt = frc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sel_nxt       = sel_r;
    hold_nxt      = hold_r;
    nm_nxt        = nm_r;
    dm_nxt        = dm_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    nneg_nxt      = nneg_r;
    dneg_nxt      = dneg_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    div_cnt_nxt   = div_cnt_r;
    num_a_nxt     = num_a_r;
    den_a_nxt     = den_a_r;
    num_b_nxt     = num_b_r;
    den_b_nxt     = den_b_r;
    neg_a_nxt     = neg_a_r;
    neg_b_nxt     = neg_b_r;
    err_nxt       = err_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      frc_pkg::S_IDLE: begin
        if (in_fire) begin
          hold_nxt = in_data;
          sel_nxt  = 1'b0;
          err_nxt  = (ad_raw == '0) || (in_data.den_b[W-1:0] == '0);
          nm_nxt   = mag_of(an_raw);
          dm_nxt   = mag_of(ad_raw);
          p_nxt    = mag_of(an_raw);
          q_nxt    = mag_of(ad_raw);
          nneg_nxt = an_raw[W-1];
          dneg_nxt = ad_raw[W-1];
        end
      end
      frc_pkg::S_EUC: begin
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        div_quo_nxt = (q_r == '0) ? nm_r : p_r;
      end
      frc_pkg::S_DIV_REM, frc_pkg::S_DIV_NUM, frc_pkg::S_DIV_DEN: begin
        div_rem_nxt = div_rem_step;
        div_quo_nxt = div_quo_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_last) begin
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          if (state_r == frc_pkg::S_DIV_REM) begin
            p_nxt = q_r;
            q_nxt = div_rem_step;
          end else if (state_r == frc_pkg::S_DIV_NUM) begin
            div_quo_nxt = dm_r;
            if (sel_r) begin
              num_b_nxt = div_quo_step;
              neg_b_nxt = frac_neg;
            end else begin
              num_a_nxt = div_quo_step;
              neg_a_nxt = frac_neg;
            end
          end else begin
            if (sel_r) begin
              den_b_nxt = div_quo_step;
            end else begin
              den_a_nxt = div_quo_step;
              sel_nxt   = 1'b1;
              nm_nxt    = mag_of(bn_raw);
              dm_nxt    = mag_of(bd_raw);
              p_nxt     = mag_of(bn_raw);
              q_nxt     = mag_of(bd_raw);
              nneg_nxt  = bn_raw[W-1];
              dneg_nxt  = bd_raw[W-1];
            end
          end
        end
      end
      frc_pkg::S_MUL_A: prod_a_nxt = mul_p;
      frc_pkg::S_MUL_B: prod_b_nxt = mul_p;
      frc_pkg::S_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_data_nxt                = '0;
            out_data_nxt.zero_den_error = 1'b1;
          end else begin
            out_data_nxt.red_num_a      = enc_num(num_a_r, neg_a_r);
            out_data_nxt.red_den_a      = 31'(sat_of(den_a_r));
            out_data_nxt.red_num_b      = enc_num(num_b_r, neg_b_r);
            out_data_nxt.red_den_b      = 31'(sat_of(den_b_r));
            out_data_nxt.order          = order_val;
            out_data_nxt.zero_den_error = 1'b0;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    nm_r       <= nm_nxt;
    dm_r       <= dm_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    nneg_r     <= nneg_nxt;
    dneg_r     <= dneg_nxt;
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    num_a_r    <= num_a_nxt;
    den_a_r    <= den_a_nxt;
    num_b_r    <= num_b_nxt;
    den_b_r    <= den_b_nxt;
    neg_a_r    <= neg_a_nxt;
    neg_b_r    <= neg_b_nxt;
    err_r      <= err_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_b_r   <= prod_b_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- design/frc_checker.sv -----
// Port checker for the fraction reduce and compare block and its bind statement.
module frc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input frc_pkg::out_t out_data
);

  // A stalled result transaction keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed.");

  // An error result carries nothing but the error flag.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_den_error |->
      out_data.red_num_a == '0 && out_data.red_den_a == '0 &&
      out_data.red_num_b == '0 && out_data.red_den_b == '0 &&
      out_data.order == frc_pkg::ORDER_A_GT)
    else $error("Error result has nonzero fields.");

  // A reduced fraction always has a positive denominator.
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_den_error |->
      out_data.red_den_a != '0 && out_data.red_den_b != '0)
    else $error("Reduced denominator is zero.");

  // The order code is one of the three defined results.
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.order == frc_pkg::ORDER_A_GT ||
                  out_data.order == frc_pkg::ORDER_B_GT ||
                  out_data.order == frc_pkg::ORDER_EQ)
    else $error("Undefined order code.");

  // A zero numerator of fraction a reduces to a denominator of one.
  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_den_error && out_data.red_num_a == '0 |->
      out_data.red_den_a == 31'd1)
    else $error("Zero numerator not reduced to a unit denominator.");

endmodule

bind fraction_reduce_and_compare_top frc_checker u_frc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
